>>> rtl/nnt_pkg.sv
// shared types and constants for the nearest-neighbour tour block
// no dependencies; imported by nnt_dist_ram and nearest_neighbor_tour
package nnt_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;
  localparam int DIST_W    = 16;
  localparam int SUM_W     = 22;
  localparam int ADDR_W    = 2 * NODE_W;

  localparam logic [SUM_W-1:0]   SUM_MAX        = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(MAX_NODES);

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_SOLVE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] row_node;
    logic [NODE_W-1:0] col_node;
    logic [DIST_W-1:0] pair_distance;
  } nnt_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] tour_position;
    logic [NODE_W-1:0] tour_node;
    logic [DIST_W-1:0] edge_length;
    logic [SUM_W-1:0]  running_length;
    logic              last_in_tour;
  } nnt_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD2,
    ST_EMIT,
    ST_SCAN,
    ST_DRAIN
  } nnt_state_e;

endpackage

>>> rtl/nnt_dist_ram.sv
// distance store: one write port, one registered read port
// depends on nnt_pkg for address and data widths
module nnt_dist_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [nnt_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [nnt_pkg::DIST_W-1:0]  wdata_i,
  input  logic [nnt_pkg::ADDR_W-1:0]  raddr_i,
  output logic [nnt_pkg::DIST_W-1:0]  rdata_o
);
  import nnt_pkg::*;

  logic [DIST_W-1:0] mem [(1 << ADDR_W)];
  logic [DIST_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/nearest_neighbor_tour.sv
// greedy nearest-neighbour tour: distance store, scan sequencer and result register
// depends on nnt_pkg and nnt_dist_ram
//
// A load beat writes one symmetric distance pair, one store write when the beat is
// taken and one in ST_LOAD2, through the single write port. A solve beat starts at
// node 0 and for each later tour position reads the current node's row one entry
// a cycle through one shared compare unit (ties keep the lowest index). The
// sequencer is back in idle, ready to take the next request beat, when the last
// result beat is presented; a stalled result holds the sequencer. The distance
// store is not cleared: an entry must be loaded before a solve reads it.
// node_count 0 acts as 1 and values above 64 act as 64. The running length
// saturates at its 22-bit maximum.
module nearest_neighbor_tour (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nnt_pkg::nnt_req_t             in_req_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nnt_pkg::nnt_res_t             out_res_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nnt_pkg::COUNT_W-1:0]   cfg_data_i
);
  import nnt_pkg::*;

  nnt_state_e state_q, state_d;

  logic [COUNT_W-1:0]   node_count_q;
  logic [COUNT_W-1:0]   n_q, n_d;
  logic [MAX_NODES-1:0] visited_q, visited_d;
  logic [NODE_W-1:0]    cur_q, cur_d;
  logic [NODE_W-1:0]    pos_q, pos_d;
  logic [NODE_W-1:0]    cand_q, cand_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [NODE_W-1:0]    best_node_q, best_node_d;
  logic [DIST_W-1:0]    best_dist_q, best_dist_d;
  logic                 found_q, found_d;
  logic                 pipe_vld_q, pipe_vld_d;
  logic [NODE_W-1:0]    pipe_cand_q, pipe_cand_d;
  logic [NODE_W-1:0]    ld_row_q, ld_col_q;
  logic [DIST_W-1:0]    ld_dist_q;
  logic                 out_valid_q, out_valid_d;
  nnt_res_t             out_q, out_d;

  logic                 in_accept, solve_start, load_start, emit_fire, scan_issue;
  logic                 scan_end, emit_last;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [DIST_W-1:0]    ram_wdata, ram_rdata;
  logic [SUM_W:0]       sum_ext;
  logic [COUNT_W-1:0]   n_active;

  // distance store
  nnt_dist_ram u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  // clamp node count into 1..MAX_NODES
  always_comb begin
    n_active = node_count_q;
    if (node_count_q == '0) begin
      n_active = COUNT_W'(1);
    end else if (node_count_q > COUNT_W'(MAX_NODES)) begin
      n_active = COUNT_W'(MAX_NODES);
    end
  end

  assign scan_end  = ({1'b0, cand_q} == (n_q - COUNT_W'(1)));
  assign emit_last = ({1'b0, pos_q} == (n_q - COUNT_W'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_req_i.req_type == REQ_SOLVE) ? ST_EMIT : ST_LOAD2;
        end
      end
      ST_LOAD2: state_d = ST_IDLE;
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = emit_last ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o  = 1'b1;
    emit_fire   = 1'b0;
    scan_issue  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = {in_req_i.row_node, in_req_i.col_node};
    ram_wdata   = in_req_i.pair_distance;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_we     = in_valid_i && (in_req_i.req_type == REQ_LOAD);
      end
      ST_LOAD2: begin
        ram_we    = 1'b1;
        ram_waddr = {ld_col_q, ld_row_q};
        ram_wdata = ld_dist_q;
      end
      ST_EMIT:  emit_fire  = !out_valid_q || !out_stall_i;
      ST_SCAN:  scan_issue = 1'b1;
      ST_DRAIN: ;
      default: ;
    endcase
  end

  assign in_accept   = in_valid_i && !in_stall_o;
  assign solve_start = in_accept && (in_req_i.req_type == REQ_SOLVE);
  assign load_start  = in_accept && (in_req_i.req_type == REQ_LOAD);
  assign ram_raddr   = {cur_q, cand_q};
  assign sum_ext     = {1'b0, sum_q} + (SUM_W + 1)'(best_dist_q);

  // datapath next values
  always_comb begin
    n_d         = n_q;
    visited_d   = visited_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    cand_d      = cand_q;
    sum_d       = sum_q;
    best_node_d = best_node_q;
    best_dist_d = best_dist_q;
    found_d     = found_q;
    pipe_vld_d  = 1'b0;
    pipe_cand_d = cand_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    // shared compare unit, one stored distance a cycle
    if (pipe_vld_q && (!found_q || (ram_rdata < best_dist_q))) begin
      found_d     = 1'b1;
      best_node_d = pipe_cand_q;
      best_dist_d = ram_rdata;
    end

    // solve start clears the walk state
    if (solve_start) begin
      n_d         = n_active;
      visited_d   = '0;
      cur_d       = '0;
      pos_d       = '0;
      sum_d       = '0;
      best_node_d = '0;
      best_dist_d = '0;
    end

    // issue one candidate read per cycle
    if (scan_issue) begin
      pipe_vld_d = !visited_q[cand_q] && (cand_q != cur_q);
      cand_d     = cand_q + NODE_W'(1);
    end

    // move to the chosen node and present the result beat
    if (emit_fire) begin
      visited_d[best_node_q] = 1'b1;
      cur_d                  = best_node_q;
      sum_d                  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      pos_d                  = pos_q + NODE_W'(1);
      cand_d                 = NODE_W'(1);
      found_d                = 1'b0;
      out_valid_d            = 1'b1;
      out_d.tour_position    = pos_q;
      out_d.tour_node        = best_node_q;
      out_d.edge_length      = best_dist_q;
      out_d.running_length   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      out_d.last_in_tour     = emit_last;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      visited_q   <= '0;
      cur_q       <= '0;
      sum_q       <= '0;
      pos_q       <= '0;
      n_q         <= NODE_COUNT_RST;
      cand_q      <= '0;
      found_q     <= 1'b0;
      pipe_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      cur_q       <= cur_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      n_q         <= n_d;
      cand_q      <= cand_d;
      found_q     <= found_d;
      pipe_vld_q  <= pipe_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    best_node_q <= best_node_d;
    best_dist_q <= best_dist_d;
    pipe_cand_q <= pipe_cand_d;
    out_q       <= out_d;
    if (load_start) begin
      ld_row_q  <= in_req_i.row_node;
      ld_col_q  <= in_req_i.col_node;
      ld_dist_q <= in_req_i.pair_distance;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // a candidate in flight was never visited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_vld_q |-> !visited_q[pipe_cand_q])
    else $error("visited node reached the compare unit");

  // a node chosen after the start is fresh
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && pos_q != '0) |-> !visited_q[best_node_q])
    else $error("chosen node already visited");

  // each result beat marks exactly one more node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> ($countones(visited_q) == int'($past(pos_q)) + 1))
    else $error("visited count out of step with tour position");

  // the last beat returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && emit_last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after last beat");

endmodule

>>> tb/tb_nearest_neighbor_tour.sv
// self-checking testbench for the nearest-neighbour tour block
// depends on nnt_pkg and nearest_neighbor_tour; predicts every tour beat on the side
module tb_nearest_neighbor_tour;
  timeunit 1ns;
  timeprecision 1ps;

  import nnt_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_BEATS = 170;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_NODES   = 18;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  nnt_req_t            in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  nnt_res_t            out_res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [COUNT_W-1:0]  cfg_data_i  = '0;

  // shadow of the block: distance store, written flags and node count
  logic [DIST_W-1:0]   dist_mem   [MAX_NODES][MAX_NODES];
  bit                  dist_known [MAX_NODES][MAX_NODES];
  logic [COUNT_W-1:0]  node_count_q = NODE_COUNT_RST;
  nnt_res_t            tour_expect_q[$];

  int                  error_count = 0;
  int                  beats_sent  = 0;
  int                  idle_cycles = 0;
  bit                  calm_mode   = 1'b0;
  int                  rx_hold_req = 0;
  int                  rx_hold_left = 0;
  int                  rx_wait_left = 0;

  nearest_neighbor_tour DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int active_count(logic [COUNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_NODES) return MAX_NODES;
    return int'(v);
  endfunction

  // mix of extremes, small values that tie often, and full-range values
  function automatic logic [DIST_W-1:0] rand_dist();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick <= 4) return DIST_W'($urandom_range(0, 3));
    return DIST_W'($urandom);
  endfunction

  function automatic nnt_req_t load_beat(int row, int col, logic [DIST_W-1:0] d);
    nnt_req_t r;
    r.req_type      = REQ_LOAD;
    r.row_node      = NODE_W'(row);
    r.col_node      = NODE_W'(col);
    r.pair_distance = d;
    return r;
  endfunction

  function automatic nnt_req_t solve_beat();
    nnt_req_t r;
    r               = nnt_req_t'($urandom);
    r.req_type      = REQ_SOLVE;
    return r;
  endfunction

  // append one predicted beat to the expected list
  function automatic void queue_expected(input nnt_res_t r);
    tour_expect_q = {tour_expect_q, r};
  endfunction

  // greedy walk from node 0, lowest index wins a tie
  task automatic predict_tour();
    int                n;
    int                cur;
    int                best;
    logic [63:0]       seen;
    logic [DIST_W-1:0] best_d;
    logic [SUM_W-1:0]  total;
    logic [SUM_W:0]    wide;
    bit                found;
    nnt_res_t          r;
    n      = active_count(node_count_q);
    seen   = 64'd1;
    cur    = 0;
    total  = '0;
    best   = 0;
    best_d = '0;
    r.tour_position  = '0;
    r.tour_node      = '0;
    r.edge_length    = '0;
    r.running_length = '0;
    r.last_in_tour   = (n == 1);
    queue_expected(r);
    for (int pos = 1; pos < n; pos++) begin
      found = 1'b0;
      for (int cand = 1; cand < n; cand++) begin
        if (!seen[cand] && (!found || dist_mem[cur][cand] < best_d)) begin
          found  = 1'b1;
          best   = cand;
          best_d = dist_mem[cur][cand];
        end
      end
      seen[best] = 1'b1;
      cur        = best;
      wide       = {1'b0, total} + best_d;
      total      = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
      r.tour_position  = NODE_W'(pos);
      r.tour_node      = NODE_W'(best);
      r.edge_length    = best_d;
      r.running_length = total;
      r.last_in_tour   = (pos == n - 1);
      queue_expected(r);
    end
  endtask

  // offer one beat after a random gap and update the shadow once it is taken
  task automatic send_req(input nnt_req_t r);
    int gap;
    gap = calm_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (r.req_type == REQ_LOAD) begin
      dist_mem[r.row_node][r.col_node]   = r.pair_distance;
      dist_mem[r.col_node][r.row_node]   = r.pair_distance;
      dist_known[r.row_node][r.col_node] = 1'b1;
      dist_known[r.col_node][r.row_node] = 1'b1;
    end else begin
      predict_tour();
    end
  endtask

  // drop valid, let every expected beat arrive and any load finish its writes
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (tour_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_node_count(input logic [COUNT_W-1:0] v);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_count_q = v;
  endtask

  // load every pair among the first n nodes that has not been written yet
  task automatic fill_pairs(input int n);
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (!dist_known[i][j]) begin
          if ($urandom_range(0, 1)) send_req(load_beat(j, i, rand_dist()));
          else send_req(load_beat(i, j, rand_dist()));
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input nnt_res_t got);
    nnt_res_t want;
    if (tour_expect_q.size() == 0) begin
      report_mismatch("result beat with nothing pending, node", got.tour_node, 0);
    end else begin
      want = tour_expect_q.pop_front();
      if (got.tour_position != want.tour_position)
        report_mismatch("tour_position", got.tour_position, want.tour_position);
      if (got.tour_node != want.tour_node)
        report_mismatch("tour_node", got.tour_node, want.tour_node);
      if (got.edge_length != want.edge_length)
        report_mismatch("edge_length", got.edge_length, want.edge_length);
      if (got.running_length != want.running_length)
        report_mismatch("running_length", got.running_length, want.running_length);
      if (got.last_in_tour != want.last_in_tour)
        report_mismatch("last_in_tour", got.last_in_tour, want.last_in_tour);
    end
  endtask

  // result side: check each beat taken, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result(out_res_o);
        rx_wait_left = calm_mode ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_wait_left > 0) begin
        rx_wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one node, and a count of zero that acts as one
  task automatic test_single_node();
    set_node_count(COUNT_W'(1));
    send_req(solve_beat());
    set_node_count(COUNT_W'(0));
    send_req(solve_beat());
  endtask

  // ties go to the lowest node, loads are symmetric, diagonal writes are unused
  task automatic test_ties_and_symmetry();
    set_node_count(COUNT_W'(3));
    send_req(load_beat(0, 1, DIST_W'(5)));
    send_req(load_beat(2, 0, DIST_W'(5)));
    send_req(load_beat(1, 2, '0));
    send_req(load_beat(1, 1, DIST_W'(9)));
    send_req(solve_beat());
    send_req(load_beat(2, 0, DIST_W'(4)));
    send_req(solve_beat());
    send_req(load_beat(1, 2, '1));
    send_req(load_beat(0, 0, '1));
    send_req(solve_beat());
    set_node_count(COUNT_W'(2));
    send_req(load_beat(1, 0, '1));
    send_req(solve_beat());
  endtask

  // random phases: new count, random loads and noise, fill the gaps, solve
  task automatic test_random_tours();
    int start;
    int n;
    int pick;
    int extra;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) n = $urandom_range(1, 8);
      else if (pick <= 8) n = $urandom_range(9, 16);
      else n = 0;
      calm_mode = ($urandom_range(0, 3) == 0);
      set_node_count(COUNT_W'(n));
      n = active_count(COUNT_W'(n));
      extra = $urandom_range(0, 6);
      for (int k = 0; k < extra; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_req(load_beat($urandom_range(0, 63), $urandom_range(0, 63), rand_dist()));
        else
          send_req(load_beat($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                             rand_dist()));
      end
      fill_pairs(n);
      send_req(solve_beat());
      if ($urandom_range(0, 2) == 0) begin
        send_req(load_beat($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                           rand_dist()));
        send_req(solve_beat());
      end
    end
    calm_mode = 1'b0;
  endtask

  // long result hold-off while beats keep coming, so the input side backs up
  task automatic test_backpressure();
    set_node_count(COUNT_W'(6));
    fill_pairs(6);
    rx_hold_req = 200;
    send_req(solve_beat());
    for (int k = 0; k < 8; k++)
      send_req(load_beat($urandom_range(0, 5), $urandom_range(0, 5), rand_dist()));
    send_req(solve_beat());
  endtask

  // longer tour over a wider node set, then reloads anywhere and a second solve
  task automatic test_long_tour();
    set_node_count(COUNT_W'(LONG_NODES));
    fill_pairs(LONG_NODES);
    send_req(solve_beat());
    for (int k = 0; k < 12; k++)
      send_req(load_beat($urandom_range(0, 63), $urandom_range(0, 63), rand_dist()));
    send_req(solve_beat());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_node();
    test_ties_and_symmetry();
    test_random_tours();
    test_backpressure();
    test_long_tour();
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && tour_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
